>>> hdl/csma_pkg.sv
// ----------------------------------------------------------------------------
// csma_pkg: shared types and constants
// Node count, widths, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package csma_pkg;

	localparam int NODES     = 16;
	localparam int IDX_W     = $clog2(NODES);
	localparam int RANGES    = 4;
	localparam int RANGE_W   = 10;
	localparam int LEN_W     = 12;
	localparam int SLOT_W    = 32;
	localparam int DVD_W     = SLOT_W + 1;
	localparam int MOD_CNT_W = $clog2(DVD_W + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT  = 3'd0,
		REG_PACKET_LEN  = 3'd1,
		REG_MAX_RETRIES = 3'd2,
		REG_RANGE_0     = 3'd3,
		REG_RANGE_1     = 3'd4,
		REG_RANGE_2     = 3'd5,
		REG_RANGE_3     = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MK_INIT = 2'd0,
		MK_FIN  = 2'd1,
		MK_COLL = 2'd2
	} mod_kind_t;

	typedef enum logic [3:0] {
		S_INIT_START,
		S_INIT_WAIT,
		S_IDLE,
		S_BUSY,
		S_FIN_WAIT,
		S_CD,
		S_SCAN,
		S_DECIDE,
		S_SEIZE,
		S_COLL,
		S_COLL_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic      idx_clr;
		logic      idx_inc;
		logic      idx_sender;
		logic      idx_last;
		logic      mod_start;
		mod_kind_t mod_kind;
		logic      init_node;
		logic      fin_node;
		logic      coll_node;
		logic      bo_dec;
		logic      rem_dec;
		logic      succ;
		logic      coll_evt;
		logic      rdy_clr;
		logic      rdy_upd;
		logic      busy_clr;
		logic      seize;
		logic      chan_clr;
		logic      take;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic       cfg_hit;
		logic       idx_end;
		logic       idx_active;
		logic       bo_zero;
		logic       rem_zero;
		logic [1:0] rdy_cnt;
		logic       mod_done;
		logic       mod_zero;
		logic       busy;
		logic       out_free;
	} sts_t;

endpackage

>>> hdl/csma_mod.sv
// ----------------------------------------------------------------------------
// csma_mod: serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder
// of a 33-bit dividend by a 10-bit modulus, zero for a zero modulus.
// ----------------------------------------------------------------------------
module csma_mod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [csma_pkg::DVD_W-1:0]       dividend,
	input  logic [csma_pkg::RANGE_W-1:0]     divisor,
	output logic                             done,
	output logic [csma_pkg::RANGE_W-1:0]     rem
);
	import csma_pkg::*;

	logic [DVD_W-1:0]     dvd_q;
	logic [RANGE_W-1:0]   dsr_q;
	logic [RANGE_W-1:0]   rem_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [RANGE_W:0]     trial;
	logic [RANGE_W:0]     diff;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= MOD_CNT_W'(DVD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == MOD_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q})
				rem_q <= diff[RANGE_W-1:0];
			else
				rem_q <= trial[RANGE_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = (dsr_q == '0) ? '0 : rem_q;

endmodule

>>> hdl/csma_dp.sv
// ----------------------------------------------------------------------------
// csma_dp: node state and channel datapath
// Configuration registers, per-node backoff, collision and remaining
// stores, channel state, totals and the result register.
// ----------------------------------------------------------------------------
module csma_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  csma_pkg::cmd_t                     cmd,
	output csma_pkg::sts_t                     sts,
	input  logic                               cfg_we,
	input  logic [csma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csma_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic [csma_pkg::SLOT_W-1:0]        time_slot,
	input  logic                               last_slot,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic                               slot_success,
	output logic                               slot_collision,
	output logic                               channel_busy,
	output logic [csma_pkg::SLOT_W-1:0]        success_total,
	output logic [csma_pkg::SLOT_W-1:0]        collision_total,
	output logic                               final_result
);
	import csma_pkg::*;

	logic [4:0]         node_count_q;
	logic [LEN_W-1:0]   packet_len_q;
	logic [2:0]         max_retries_q;
	logic [RANGE_W-1:0] range_q [RANGES];

	logic [RANGE_W-1:0] bo_q [NODES];
	logic [1:0]         co_q [NODES];
	logic [LEN_W-1:0]   rm_q [NODES];

	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   sender_q;
	logic [IDX_W-1:0]   last_q;
	logic [1:0]         rdy_q;
	logic               busy_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               fin_q;
	logic               succ_q;
	logic               coll_q;
	logic [SLOT_W-1:0]  succ_tot_q;
	logic [SLOT_W-1:0]  coll_tot_q;
	logic               out_valid_q;

	logic [RANGE_W-1:0] cur_bo;
	logic [1:0]         cur_co;
	logic [LEN_W-1:0]   cur_rm;
	logic [2:0]         limit;
	logic [2:0]         c_next;
	logic               c_wrap;
	logic [DVD_W-1:0]   dividend;
	logic [RANGE_W-1:0] divisor;
	logic               mod_done;
	logic [RANGE_W-1:0] mod_rem;
	logic               active;

	assign cur_bo = bo_q[idx_q];
	assign cur_co = co_q[idx_q];
	assign cur_rm = rm_q[idx_q];
	assign active = {1'b0, idx_q} < node_count_q;
	assign limit  = (max_retries_q > 3'(RANGES)) ? 3'(RANGES) : max_retries_q;
	assign c_next = {1'b0, cur_co} + 3'd1;
	assign c_wrap = c_next >= limit;

	always_comb begin
		dividend = '0;
		divisor  = range_q[0];
		case (cmd.mod_kind)
			MK_INIT: dividend = DVD_W'(idx_q);
			MK_FIN:  dividend = {1'b0, slot_q} + DVD_W'(idx_q);
			MK_COLL: begin
				dividend = {1'b0, slot_q} + DVD_W'(idx_q) + DVD_W'(1);
				if (!c_wrap)
					divisor = range_q[c_next[1:0]];
			end
			default: dividend = '0;
		endcase
	end

	csma_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= 5'd1;
			packet_len_q  <= LEN_W'(1);
			max_retries_q <= 3'd4;
			for (int i = 0; i < RANGES; i++)
				range_q[i] <= RANGE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT:  node_count_q  <= cfg_data[4:0];
				REG_PACKET_LEN:  packet_len_q  <= cfg_data[LEN_W-1:0];
				REG_MAX_RETRIES: max_retries_q <= cfg_data[2:0];
				REG_RANGE_0:     range_q[0]    <= cfg_data[RANGE_W-1:0];
				REG_RANGE_1:     range_q[1]    <= cfg_data[RANGE_W-1:0];
				REG_RANGE_2:     range_q[2]    <= cfg_data[RANGE_W-1:0];
				REG_RANGE_3:     range_q[3]    <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// node stores, one node a cycle at idx_q
	always_ff @(posedge clk) begin
		if (cmd.init_node) begin
			bo_q[idx_q] <= mod_rem;
			co_q[idx_q] <= '0;
			rm_q[idx_q] <= packet_len_q;
		end else if (cmd.fin_node) begin
			bo_q[idx_q] <= mod_rem;
			co_q[idx_q] <= '0;
			rm_q[idx_q] <= (mod_rem == '0) ? packet_len_q - 1'b1 : packet_len_q;
		end else if (cmd.coll_node) begin
			bo_q[idx_q] <= mod_rem;
			co_q[idx_q] <= c_wrap ? 2'd0 : c_next[1:0];
		end else begin
			if (cmd.bo_dec && active && cur_bo != '0)
				bo_q[idx_q] <= cur_bo - 1'b1;
			if (cmd.rem_dec)
				rm_q[idx_q] <= cur_rm - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sender_q    <= '0;
			last_q      <= '0;
			rdy_q       <= '0;
			busy_q      <= 1'b0;
			succ_q      <= 1'b0;
			coll_q      <= 1'b0;
			succ_tot_q  <= '0;
			coll_tot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			else if (cmd.idx_sender)
				idx_q <= sender_q;
			else if (cmd.idx_last)
				idx_q <= last_q;

			if (cmd.rdy_clr)
				rdy_q <= '0;
			else if (cmd.rdy_upd && active && cur_bo == '0) begin
				last_q <= idx_q;
				if (rdy_q != 2'd2)
					rdy_q <= rdy_q + 1'b1;
			end

			if (cmd.chan_clr) begin
				busy_q   <= 1'b0;
				sender_q <= '0;
			end else if (cmd.seize) begin
				busy_q   <= 1'b1;
				sender_q <= last_q;
			end else if (cmd.busy_clr)
				busy_q <= 1'b0;

			if (cmd.take) begin
				succ_q <= 1'b0;
				coll_q <= 1'b0;
			end
			if (cmd.succ) begin
				succ_q     <= 1'b1;
				succ_tot_q <= succ_tot_q + 1'b1;
			end
			if (cmd.coll_evt) begin
				coll_q     <= 1'b1;
				coll_tot_q <= coll_tot_q + 1'b1;
			end

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			slot_q <= time_slot;
			fin_q  <= last_slot;
		end
		if (cmd.out_load) begin
			slot_success    <= succ_q;
			slot_collision  <= coll_q;
			channel_busy    <= busy_q;
			success_total   <= succ_tot_q;
			collision_total <= coll_tot_q;
			final_result    <= fin_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.cfg_hit    = cfg_we && (cfg_index <= REG_RANGE_3);
		sts.idx_end    = idx_q == IDX_W'(NODES - 1);
		sts.idx_active = active;
		sts.bo_zero    = cur_bo == '0;
		sts.rem_zero   = cur_rm == '0;
		sts.rdy_cnt    = rdy_q;
		sts.mod_done   = mod_done;
		sts.mod_zero   = mod_rem == '0;
		sts.busy       = busy_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

`ifndef NO_ASSERTIONS
	a_seize_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seize |-> !busy_q)
		else $error("channel seized while busy");
	a_excl_event: assert property (@(posedge clk) disable iff (!arst_n)
		!(succ_q && coll_q))
		else $error("success and collision in one slot");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");
	a_dec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem_dec |=> busy_q)
		else $error("packet slot sent on idle channel");
`endif

endmodule

>>> hdl/csma_ctrl.sv
// ----------------------------------------------------------------------------
// csma_ctrl: slot sequencer
// Walks the node stores for initialization, readiness scan, collision
// redraws and countdown, and hands each slot result to the output.
// ----------------------------------------------------------------------------
module csma_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  csma_pkg::sts_t  sts,
	output csma_pkg::cmd_t  cmd
);
	import csma_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT_START;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		if (sts.cfg_hit) begin
			// restart the node initialization on any register write
			cmd.idx_clr  = 1'b1;
			cmd.chan_clr = 1'b1;
			state_d      = S_INIT_START;
		end else begin
			case (state_q)
				S_INIT_START: begin
					cmd.mod_start = 1'b1;
					cmd.mod_kind  = MK_INIT;
					state_d       = S_INIT_WAIT;
				end
				S_INIT_WAIT: begin
					cmd.mod_kind = MK_INIT;
					if (sts.mod_done) begin
						cmd.init_node = 1'b1;
						if (sts.idx_end)
							state_d = S_IDLE;
						else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_INIT_START;
						end
					end
				end
				S_IDLE: begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.take = 1'b1;
						if (sts.busy) begin
							cmd.idx_sender = 1'b1;
							state_d        = S_BUSY;
						end else begin
							cmd.idx_clr = 1'b1;
							cmd.rdy_clr = 1'b1;
							state_d     = S_SCAN;
						end
					end
				end
				S_BUSY: begin
					if (!sts.rem_zero) begin
						cmd.rem_dec = 1'b1;
						cmd.succ    = 1'b1;
						state_d     = S_DONE;
					end else begin
						cmd.mod_start = 1'b1;
						cmd.mod_kind  = MK_FIN;
						state_d       = S_FIN_WAIT;
					end
				end
				S_FIN_WAIT: begin
					cmd.mod_kind = MK_FIN;
					if (sts.mod_done) begin
						cmd.fin_node = 1'b1;
						if (sts.mod_zero) begin
							cmd.succ = 1'b1;
							state_d  = S_DONE;
						end else begin
							cmd.busy_clr = 1'b1;
							cmd.idx_clr  = 1'b1;
							state_d      = S_CD;
						end
					end
				end
				S_CD: begin
					cmd.bo_dec = 1'b1;
					if (sts.idx_end)
						state_d = S_DONE;
					else
						cmd.idx_inc = 1'b1;
				end
				S_SCAN: begin
					cmd.rdy_upd = 1'b1;
					if (sts.idx_end)
						state_d = S_DECIDE;
					else
						cmd.idx_inc = 1'b1;
				end
				S_DECIDE: begin
					case (sts.rdy_cnt)
						2'd0: begin
							cmd.idx_clr = 1'b1;
							state_d     = S_CD;
						end
						2'd1: begin
							cmd.seize    = 1'b1;
							cmd.idx_last = 1'b1;
							state_d      = S_SEIZE;
						end
						default: begin
							cmd.coll_evt = 1'b1;
							cmd.idx_clr  = 1'b1;
							state_d      = S_COLL;
						end
					endcase
				end
				S_SEIZE: begin
					cmd.rem_dec = 1'b1;
					cmd.succ    = 1'b1;
					state_d     = S_DONE;
				end
				S_COLL: begin
					cmd.mod_kind = MK_COLL;
					if (sts.idx_active && sts.bo_zero) begin
						cmd.mod_start = 1'b1;
						state_d       = S_COLL_WAIT;
					end else if (sts.idx_end)
						state_d = S_DONE;
					else
						cmd.idx_inc = 1'b1;
				end
				S_COLL_WAIT: begin
					cmd.mod_kind = MK_COLL;
					if (sts.mod_done) begin
						cmd.coll_node = 1'b1;
						if (sts.idx_end)
							state_d = S_DONE;
						else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_COLL;
						end
					end
				end
				S_DONE: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						state_d      = S_IDLE;
					end
				end
				default: state_d = S_INIT_START;
			endcase
		end
	end

endmodule

>>> hdl/slotted_csma_backoff_sim.sv
// Each slot is handled mid-packet, at packet end when the sender keeps the channel or
// counts down, or on an idle channel as a seized slot, an idle countdown or a collision.
// Each serial remainder holds the sequencer until it is done; each node walk visits all 16 nodes.
// One slot is in work at a time; the next is accepted only after its result is loaded.
// Reset and every register write reinitialize the 16 nodes, no slot accepted meanwhile.
// ----------------------------------------------------------------------------
// slotted_csma_backoff_sim: slotted CSMA channel with exponential backoff
// Per slot reports success, collision, channel state and wrapping totals.
// ----------------------------------------------------------------------------
module slotted_csma_backoff_sim (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [csma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csma_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [csma_pkg::SLOT_W-1:0]        time_slot,
	input  logic                               last_slot,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               slot_success,
	output logic                               slot_collision,
	output logic                               channel_busy,
	output logic [csma_pkg::SLOT_W-1:0]        success_total,
	output logic [csma_pkg::SLOT_W-1:0]        collision_total,
	output logic                               final_result
);
	import csma_pkg::*;

	cmd_t cmd;
	sts_t sts;

	csma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csma_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.time_slot       (time_slot),
		.last_slot       (last_slot),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.slot_success    (slot_success),
		.slot_collision  (slot_collision),
		.channel_busy    (channel_busy),
		.success_total   (success_total),
		.collision_total (collision_total),
		.final_result    (final_result)
	);

endmodule

>>> sim/tb_slotted_csma_backoff_sim.sv
// ----------------------------------------------------------------------------
// tb_slotted_csma_backoff_sim: self-checking bench for the CSMA slot model
// Runs phases of node and backoff settings. Each phase feeds slot transactions,
// with random sender gaps and receiver stalls depending on its mode. A channel
// predictor in the scoreboard produces the expected per-slot flags and
// totals, and each result is checked against them in order.
// ----------------------------------------------------------------------------
module tb_slotted_csma_backoff_sim;
	import csma_pkg::*;

	typedef struct packed {
		logic        success;
		logic        collision;
		logic        busy;
		logic [31:0] succ_total;
		logic [31:0] coll_total;
		logic        final_flag;
	} slot_report_t;

	class channel_scoreboard;
		logic [4:0]   node_cnt;
		logic [11:0]  pkt_len;
		logic [2:0]   retry_lim;
		logic [9:0]   modulus[RANGES];
		logic [9:0]   backoff[NODES];
		logic [1:0]   coll_cnt[NODES];
		logic [11:0]  remaining[NODES];
		logic         busy;
		logic [3:0]   sender;
		logic [31:0]  succ_cnt;
		logic [31:0]  coll_evt_cnt;
		slot_report_t expected_q[$];
		int           errors;
		int           checked;
		int           n_succ;
		int           n_coll;

		function new();
			node_cnt = 1;
			pkt_len = 1;
			retry_lim = 4;
			foreach (modulus[i]) modulus[i] = 1;
			succ_cnt = 0;
			coll_evt_cnt = 0;
			errors = 0;
			checked = 0;
			n_succ = 0;
			n_coll = 0;
			reinit();
		endfunction

		function logic [9:0] draw(logic [32:0] sum, logic [9:0] m);
			if (m == 0) return 0;
			return 10'(sum % m);
		endfunction

		function void reinit();
			for (int i = 0; i < NODES; i++) begin
				backoff[i] = draw(33'(i), modulus[0]);
				coll_cnt[i] = 0;
				remaining[i] = pkt_len;
			end
			busy = 0;
			sender = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [11:0] value);
			case (idx)
				REG_NODE_COUNT:  node_cnt = value[4:0];
				REG_PACKET_LEN:  pkt_len = value;
				REG_MAX_RETRIES: retry_lim = value[2:0];
				REG_RANGE_0:     modulus[0] = value[9:0];
				REG_RANGE_1:     modulus[1] = value[9:0];
				REG_RANGE_2:     modulus[2] = value[9:0];
				REG_RANGE_3:     modulus[3] = value[9:0];
				default: ;
			endcase
			reinit();
		endfunction

		function int active();
			return (node_cnt > NODES) ? NODES : node_cnt;
		endfunction

		function void count_down();
			for (int i = 0; i < active(); i++)
				if (backoff[i] != 0) backoff[i]--;
		endfunction

		function void send_one(int k);
			remaining[k] = remaining[k] - 1;
			succ_cnt++;
		endfunction

		// advance the channel by one slot and queue its report
		function void note_slot(logic [31:0] slot, logic last);
			slot_report_t r;
			int ready;
			int last_rdy;
			int lim;
			logic [2:0] c;
			r = '0;
			if (busy) begin
				if (remaining[sender] == 0) begin
					coll_cnt[sender] = 0;
					backoff[sender] = draw(33'(sender) + 33'(slot), modulus[0]);
					remaining[sender] = pkt_len;
					if (backoff[sender] == 0) begin
						send_one(sender);
						r.success = 1;
					end else begin
						busy = 0;
						count_down();
					end
				end else begin
					send_one(sender);
					r.success = 1;
				end
			end else begin
				ready = 0;
				last_rdy = 0;
				for (int i = 0; i < active(); i++)
					if (backoff[i] == 0) begin
						ready++;
						last_rdy = i;
					end
				if (ready == 1) begin
					sender = 4'(last_rdy);
					busy = 1;
					send_one(last_rdy);
					r.success = 1;
				end else if (ready > 1) begin
					lim = (retry_lim < RANGES) ? retry_lim : RANGES;
					coll_evt_cnt++;
					r.collision = 1;
					for (int i = 0; i < active(); i++) begin
						if (backoff[i] == 0) begin
							c = coll_cnt[i] + 1;
							if (c >= lim) begin
								coll_cnt[i] = 0;
								backoff[i] = draw(33'(i) + 33'(slot) + 1, modulus[0]);
							end else begin
								coll_cnt[i] = c[1:0];
								backoff[i] = draw(33'(i) + 33'(slot) + 1, modulus[c]);
							end
						end
					end
				end else begin
					count_down();
				end
			end
			r.busy = busy;
			r.succ_total = succ_cnt;
			r.coll_total = coll_evt_cnt;
			r.final_flag = last;
			n_succ += r.success;
			n_coll += r.collision;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_slot(slot_report_t got);
			slot_report_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.success !== e.success)
				$display("%0t: slot_success exp %0d got %0d", $time, e.success, got.success);
			if (got.collision !== e.collision)
				$display("%0t: slot_collision exp %0d got %0d", $time, e.collision,
					got.collision);
			if (got.busy !== e.busy)
				$display("%0t: channel_busy exp %0d got %0d", $time, e.busy, got.busy);
			if (got.succ_total !== e.succ_total)
				$display("%0t: success_total exp %0d got %0d", $time, e.succ_total,
					got.succ_total);
			if (got.coll_total !== e.coll_total)
				$display("%0t: collision_total exp %0d got %0d", $time, e.coll_total,
					got.coll_total);
			if (got.final_flag !== e.final_flag)
				$display("%0t: final_result exp %0d got %0d", $time, e.final_flag,
					got.final_flag);
			if (got !== e) errors++;
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 6000000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic [SLOT_W-1:0]    time_slot = '0;
	logic                 last_slot = 0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic                 slot_success;
	logic                 slot_collision;
	logic                 channel_busy;
	logic [SLOT_W-1:0]    success_total;
	logic [SLOT_W-1:0]    collision_total;
	logic                 final_result;

	channel_scoreboard sb = new();
	int  idle_mode = 0;
	int  stall_hold = 0;
	int  cycles = 0;
	int  sent = 0;
	logic [31:0] slot_no;

	slotted_csma_backoff_sim DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			sb.check_slot({slot_success, slot_collision, channel_busy, success_total,
				collision_total, final_result});

	// receiver: long hold-off when requested, else stall by phase mode
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_ready <= 0;
		end else if (idle_mode == 2 || idle_mode == 3)
			out_ready <= ($urandom_range(99) >= (idle_mode == 2 ? 56 : 33));
		else
			out_ready <= 1;
	end

	task automatic send_slot(logic [31:0] slot, logic last);
		int pct;
		pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 33 : 0;
		if ($urandom_range(99) < pct) begin
			in_valid <= 0;
			do @(negedge clk); while ($urandom_range(99) < pct);
		end
		in_valid <= 1;
		time_slot <= slot;
		last_slot <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_slot(slot, last);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_regs(logic [11:0] v[7]);
		cfg_reg_t r;
		for (int i = 0; i < 7; i++) begin
			r = cfg_reg_t'(i);
			// hold off until the node reinit pass is over
			while (!in_ready) @(negedge clk);
			cfg_we <= 1;
			cfg_index <= r;
			cfg_data <= v[i];
			sb.write_reg(r, v[i]);
			@(negedge clk);
			cfg_we <= 0;
			@(negedge clk);
		end
	endtask

	task automatic run_phase(logic [11:0] v[7], int n, int mode, int hold);
		logic last;
		write_regs(v);
		idle_mode = mode;
		// start the receiver hold-off only once slots are being offered
		if (hold > 0) stall_hold = hold;
		slot_no = $urandom;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(31) == 0) slot_no = 32'hFFFF_FFFF - $urandom_range(20);
			else if ($urandom_range(15) == 0) slot_no = $urandom;
			else slot_no = slot_no + 1;
			last = (k == n - 1) || ($urandom_range(19) == 0);
			send_slot(slot_no, last);
		end
		drain();
	endtask

	initial begin
		logic [11:0] v[7];
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: slot extremes and the 33-bit draw sum under collisions
		v = '{12'd4, 12'd2, 12'd2, 12'd2, 12'd3, 12'd4, 12'd5};
		write_regs(v);
		send_slot(32'h0, 1'b0);
		send_slot(32'hFFFF_FFFF, 1'b1);
		send_slot(32'hFFFF_FFFE, 1'b0);
		for (int k = 0; k < 10; k++) send_slot(32'hFFFF_FFF0 + k, k[0]);
		for (int k = 0; k < 10; k++) send_slot(32'(k), 1'b0);
		drain();

		v = '{12'd16, 12'd3, 12'd4, 12'd1, 12'd2, 12'd4, 12'd8};
		run_phase(v, 250, 0, 0);
		// node count above the table, zero ranges, retry limit above the table
		v = '{12'd31, 12'd1, 12'd7, 12'd0, 12'd0, 12'd1023, 12'd3};
		run_phase(v, 150, 1, 0);
		// no active node, widest packet and ranges, zero retry limit
		v = '{12'd0, 12'd4095, 12'd0, 12'd1023, 12'd1023, 12'd1023, 12'd1023};
		run_phase(v, 50, 2, 0);
		// zero packet length wraps the remaining count
		v = '{12'd5, 12'd0, 12'd1, 12'd3, 12'd1, 12'd1, 12'd1};
		run_phase(v, 200, 3, 0);
		v = '{12'd8, 12'd2, 12'd3, 12'd4, 12'd6, 12'd9, 12'd13};
		run_phase(v, 250, 2, 400);
		v = '{12'd2, 12'd1, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2};
		run_phase(v, 200, 1, 0);

		idle_mode = 0;
		repeat (100) @(posedge clk);
		$display("Covered %0d slots over 7 register settings: %0d successes, %0d collisions.",
			sent, sb.n_succ, sb.n_coll);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

>>> sim.f
hdl/csma_pkg.sv
hdl/csma_mod.sv
hdl/csma_dp.sv
hdl/csma_ctrl.sv
hdl/slotted_csma_backoff_sim.sv
sim/tb_slotted_csma_backoff_sim.sv
